FILE: rtl/core/vhd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the vector heading block.
// No dependencies.
package vhd_pkg;

  localparam int COMPONENT_WIDTH   = 16;
  localparam int FRACTION_BITS_DEF = 6;
  localparam int HEADING_W         = 15;
  localparam int CORDIC_STEPS      = 32;
  // Datapath headroom: |x| stays below 2^60 after gain growth
  localparam int WORK_W            = 62;
  localparam int GUARD_SHIFT       = 59 - COMPONENT_WIDTH;
  // Angle accumulator in picodegrees, signed
  localparam int ACC_W             = 50;

  // Picodegree to degree scaling: 10^12 = 2^SCALE_POW2 * SCALE_ODD. The odd
  // factor is divided out by a reciprocal multiply on the dividend with its
  // low RECIP_LO bits dropped, followed by a single correction step.
  localparam int          SCALE_POW2  = 12;
  localparam logic [27:0] SCALE_ODD   = 28'd244140625;
  localparam int          RECIP_LO    = 24;
  localparam int          RECIP_SHIFT = 27;
  // floor(2^(RECIP_LO + RECIP_SHIFT) / SCALE_ODD)
  localparam logic [23:0] RECIP_ODD   = 24'd9223372;

  localparam logic signed [ACC_W-1:0] HALF_PDEG    = 50'sd180000000000000;
  localparam logic signed [ACC_W-1:0] FULL_PDEG    = 50'sd360000000000000;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] dir_x;
    logic signed [COMPONENT_WIDTH-1:0] dir_z;
  } vhd_in_t;

  typedef struct packed {
    logic [HEADING_W-1:0] heading;
    logic                 zero_vector;
  } vhd_out_t;

  // atan(2^-idx) in degrees, rounded to picodegrees
  function automatic logic signed [ACC_W-1:0] atan_pdeg(input int unsigned idx);
    logic signed [ACC_W-1:0] v;
    unique case (idx)
      0:  v = 50'sd45000000000000;
      1:  v = 50'sd26565051177078;
      2:  v = 50'sd14036243467926;
      3:  v = 50'sd7125016348902;
      4:  v = 50'sd3576334374997;
      5:  v = 50'sd1789910608246;
      6:  v = 50'sd895173710211;
      7:  v = 50'sd447614170861;
      8:  v = 50'sd223810500369;
      9:  v = 50'sd111905677066;
      10: v = 50'sd55952891894;
      11: v = 50'sd27976452617;
      12: v = 50'sd13988227142;
      13: v = 50'sd6994113675;
      14: v = 50'sd3497056851;
      15: v = 50'sd1748528427;
      16: v = 50'sd874264214;
      17: v = 50'sd437132107;
      18: v = 50'sd218566053;
      19: v = 50'sd109283027;
      20: v = 50'sd54641513;
      21: v = 50'sd27320757;
      22: v = 50'sd13660378;
      23: v = 50'sd6830189;
      24: v = 50'sd3415095;
      25: v = 50'sd1707547;
      26: v = 50'sd853774;
      27: v = 50'sd426887;
      28: v = 50'sd213443;
      29: v = 50'sd106722;
      30: v = 50'sd53361;
      31: v = 50'sd26680;
      default: v = '0;
    endcase
    atan_pdeg = v;
  endfunction

endpackage

FILE: rtl/core/vector_heading_degrees.sv
`timescale 1ns / 1ps
// Vector heading unit: pipelined CORDIC (vectoring) plus a reciprocal-multiply
// stage group that scales picodegrees to fixed-point degrees. Depends on vhd_pkg.
//
// Heading of a direction vector (dir_x, dir_z): atan2(dir_z, dir_x) in degrees,
// moved into [0, 360), leaving as unsigned fixed point with FRACTION_BITS
// fraction bits, truncated. A zero vector gives heading 0 with zero_vector set.
// The unit takes one transaction per clock and has one result per transaction.
// An accepted input passes through these stages and then the output queue
// before out_valid rises, for any FRACTION_BITS: one stage folds the left
// half-plane, 32 stages each run one CORDIC micro-rotation, one stage wraps the
// angle into one turn and drops the power-of-two part of the 10^12 scale, and
// three stages divide out the odd part (reciprocal multiply, back-multiply,
// one-step correction). A two-entry output queue (output register plus skid)
// lets input transactions keep entering while a result waits for out_ready; the
// pipeline holds only when both entries are full and the consumer stalls.
module vector_heading_degrees #(
  parameter int FRACTION_BITS = vhd_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vhd_pkg::vhd_in_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output vhd_pkg::vhd_out_t out_item
);
  import vhd_pkg::*;

  localparam int CS = CORDIC_STEPS;
  // Quotient bits: 360 * 2^FRACTION_BITS < 2^(9 + FRACTION_BITS)
  localparam int QB = 9 + FRACTION_BITS;
  localparam int QW = (QB > HEADING_W) ? QB : HEADING_W;
  // Wrapped angle is non-negative, so the dividend needs one bit less
  localparam int NW = ACC_W - 1;
  localparam int DSHIFT = SCALE_POW2 - FRACTION_BITS;
  // Stage 0 fold, 1..CS rotations, CS+1 wrap, CS+2..CS+4 scaling
  localparam int NS = CS + 5;

  // Global pipeline enable; valid bits ride along with the data
  logic          advance;
  logic [NS-1:0] vld;
  logic [NS-1:0] zro;

  logic signed [WORK_W-1:0] cx   [CS];
  logic signed [WORK_W-1:0] cz   [CS];
  logic signed [ACC_W-1:0]  cacc [CS+1];

  // Scaling datapath
  logic [NW-1:0] scaled;
  logic [NW-1:0] scaled_d1;
  logic [NW-1:0] scaled_d2;
  logic [NW-1:0] prod;
  logic [QB-1:0] q_est;
  logic [QB-1:0] q_base;
  logic [NW-1:0] q_times_d;
  logic [NW-1:0] rem;
  logic          round_up;
  logic [QW-1:0] quo;

  // Output queue: head register and one skid entry
  logic     skid_valid;
  vhd_out_t skid_item;
  vhd_out_t push_item;
  logic     push;

  assign advance  = !skid_valid || out_ready;
  assign in_ready = advance;
  assign push     = advance && vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      zro <= {zro[NS-2:0], (in_item.dir_x == '0) && (in_item.dir_z == '0)};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: sign-extend, fold the left half-plane by negating the vector and
  // starting the angle at 180 degrees, then scale up into the guard bits.
  // ---------------------------------------------------------------------------
  logic signed [WORK_W-1:0] x_ext, z_ext, x_fold, z_fold;
  logic                     left_half;

  always_comb begin
    x_ext     = {{(WORK_W-COMPONENT_WIDTH){in_item.dir_x[COMPONENT_WIDTH-1]}}, in_item.dir_x};
    z_ext     = {{(WORK_W-COMPONENT_WIDTH){in_item.dir_z[COMPONENT_WIDTH-1]}}, in_item.dir_z};
    left_half = in_item.dir_x[COMPONENT_WIDTH-1];
    x_fold    = left_half ? -x_ext : x_ext;
    z_fold    = left_half ? -z_ext : z_ext;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cx[0]   <= x_fold <<< GUARD_SHIFT;
      cz[0]   <= z_fold <<< GUARD_SHIFT;
      cacc[0] <= left_half ? HALF_PDEG : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1..CS: one micro-rotation each. Drive z toward zero; the arithmetic
  // shifts floor toward minus infinity. z equal to zero rotates the negative way.
  // ---------------------------------------------------------------------------
  for (genvar s = 1; s <= CS; s++) begin : g_rot
    localparam int SH = s - 1;
    logic up;

    assign up = (cz[s-1] > 0);

    always_ff @(posedge clk) begin
      if (advance) begin
        cacc[s] <= up ? cacc[s-1] + atan_pdeg(SH) : cacc[s-1] - atan_pdeg(SH);
      end
    end

    // The last rotation only needs its angle
    if (s < CS) begin : g_xz
      logic signed [WORK_W-1:0] xs, zs;

      assign xs = cx[s-1] >>> SH;
      assign zs = cz[s-1] >>> SH;

      always_ff @(posedge clk) begin
        if (advance) begin
          cx[s] <= up ? cx[s-1] + zs : cx[s-1] - zs;
          cz[s] <= up ? cz[s-1] - xs : cz[s-1] + xs;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage CS+1: wrap the angle into [0, 360) degrees, then drop the power-of-two
  // part of the picodegree-to-degree scale (2^SCALE_POW2 / 2^FRACTION_BITS).
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_wrap;

  always_comb begin
    priority if (cacc[CS] < 0) begin
      acc_wrap = cacc[CS] + FULL_PDEG;
    end else if (cacc[CS] >= FULL_PDEG) begin
      acc_wrap = cacc[CS] - FULL_PDEG;
    end else begin
      acc_wrap = cacc[CS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      scaled <= acc_wrap[ACC_W-1] ? '0 : (acc_wrap[ACC_W-2:0] >> DSHIFT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages CS+2..CS+4: divide by SCALE_ODD. The reciprocal estimate on the top
  // bits never overshoots and falls short by at most one, so one compare of the
  // remainder against the divisor finishes the quotient.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (advance) begin
      prod      <= NW'(scaled[NW-1:RECIP_LO]) * NW'(RECIP_ODD);
      scaled_d1 <= scaled;
    end
  end

  assign q_est = prod[RECIP_SHIFT +: QB];

  always_ff @(posedge clk) begin
    if (advance) begin
      q_base    <= q_est;
      q_times_d <= NW'(q_est) * NW'(SCALE_ODD);
      scaled_d2 <= scaled_d1;
    end
  end

  assign rem      = scaled_d2 - q_times_d;
  assign round_up = (rem >= NW'(SCALE_ODD));

  always_ff @(posedge clk) begin
    if (advance) begin
      quo <= QW'(q_base) + QW'(round_up);
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue. Refill the head from the skid entry first to keep order.
  // ---------------------------------------------------------------------------
  always_comb begin
    push_item.heading     = zro[NS-1] ? '0 : quo[HEADING_W-1:0];
    push_item.zero_vector = zro[NS-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_item  <= skid_valid ? skid_item : push_item;
      skid_item <= push_item;
    end else if (push) begin
      skid_item <= push_item;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  localparam logic          CHK_RANGE = (QB <= HEADING_W);
  localparam logic [QW-1:0] HLIM      = QW'(360) << FRACTION_BITS;

  // The skid entry is only ever filled behind a full head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while head is empty");

  // The reciprocal estimate needs at most one correction
  a_scale_correction: assert property (@(posedge clk) disable iff (rst)
    vld[CS+3] |-> ((scaled_d2 >= q_times_d) && (rem < (NW'(SCALE_ODD) << 1))))
    else $error("quotient estimate off by more than one");

  // A heading never reaches a full turn
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!CHK_RANGE || (QW'(out_item.heading) < HLIM)))
    else $error("heading at or above 360 degrees");

  // Nothing leaves the pipeline while both queue entries are stuck
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> ($stable(skid_item) && skid_valid))
    else $error("skid entry overwritten while stalled");

endmodule

FILE: test/vector_heading_degrees_test.sv
`timescale 1ns / 1ps
// Self-checking bench for vector_heading_degrees: random traffic on both handshakes,
// with the heading of every accepted vector predicted by a local CORDIC.
// Depends on vhd_pkg and vector_heading_degrees.
module vector_heading_degrees_test;
  import vhd_pkg::*;

  // Bench-side copy of the arithmetic constants
  localparam int     SHIFT_UP     = 43;           // 59 - component width
  localparam int     FRAC         = 6;
  localparam int     ROTATIONS    = 32;
  localparam longint PDEG_PER_DEG = 64'sd1000000000000;
  localparam longint PDEG_HALF    = 180 * PDEG_PER_DEG;
  localparam longint PDEG_FULL    = 360 * PDEG_PER_DEG;
  localparam longint HEADING_TOP  = (360 << FRAC) - 1;
  localparam int     RANDOM_ITEMS = 1350;
  localparam int     MAX_WAIT     = 13;
  localparam int     TAIL_CYCLES  = 80;
  localparam int     CYCLE_LIMIT  = 250000;

  typedef struct {
    vhd_in_t  vec;
    vhd_out_t want;
  } heading_check_t;

  // atan(2^-k) in picodegrees, one entry per micro-rotation
  longint rot_angle_pdeg [0:ROTATIONS-1] = '{
    64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926, 64'sd7125016348902,
    64'sd3576334374997,  64'sd1789910608246,  64'sd895173710211,   64'sd447614170861,
    64'sd223810500369,   64'sd111905677066,   64'sd55952891894,    64'sd27976452617,
    64'sd13988227142,    64'sd6994113675,     64'sd3497056851,     64'sd1748528427,
    64'sd874264214,      64'sd437132107,      64'sd218566053,      64'sd109283027,
    64'sd54641513,       64'sd27320757,       64'sd13660378,       64'sd6830189,
    64'sd3415095,        64'sd1707547,        64'sd853774,         64'sd426887,
    64'sd213443,         64'sd106722,         64'sd53361,          64'sd26680
  };

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  vhd_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  vhd_out_t out_item;

  vhd_in_t        pending_vectors [$];   // stimulus not yet offered
  heading_check_t expected_headings [$]; // accepted vectors awaiting their heading
  heading_check_t fresh;
  heading_check_t oldest;

  bit in_took;
  bit out_took;
  int send_wait;
  bit send_burst;
  int take_wait;
  bit take_burst;
  int error_count;
  int cycle_count;

  vector_heading_degrees dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  // Heading of one vector: fold the left half-plane onto the right, run the
  // vectoring CORDIC with floor shifts, wrap into one turn, then scale the
  // picodegree angle to degrees with FRAC fraction bits, truncated.
  function automatic vhd_out_t heading_of(vhd_in_t v);
    longint   px;
    longint   pz;
    longint   sx;
    longint   sz;
    longint   angle;
    longint   deg;
    vhd_out_t r;
    r     = '0;
    px    = v.dir_x;
    pz    = v.dir_z;
    angle = 0;
    if (px == 0 && pz == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    if (px < 0) begin
      px    = -px;
      pz    = -pz;
      angle = PDEG_HALF;
    end
    px = px <<< SHIFT_UP;
    pz = pz <<< SHIFT_UP;
    for (int k = 0; k < ROTATIONS; k++) begin
      sx = px >>> k;
      sz = pz >>> k;
      if (pz > 0) begin
        px    = px + sz;
        pz    = pz - sx;
        angle = angle + rot_angle_pdeg[k];
      end else begin
        px    = px - sz;
        pz    = pz + sx;
        angle = angle - rot_angle_pdeg[k];
      end
    end
    if (angle < 0) angle = angle + PDEG_FULL;
    if (angle >= PDEG_FULL) angle = angle - PDEG_FULL;
    if (angle < 0) angle = 0;
    deg = (angle <<< FRAC) / PDEG_PER_DEG;
    // Approximation error can land exactly on 360; clamp just below it
    if (deg > HEADING_TOP) deg = HEADING_TOP;
    r.heading = deg[HEADING_W-1:0];
    return r;
  endfunction

  task automatic queue_vector(int x, int z);
    vhd_in_t v;
    v.dir_x = 16'(x);
    v.dir_z = 16'(z);
    pending_vectors.push_back(v);
  endtask

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // Sample both handshakes at the rising edge. Record the expected heading
  // for each accepted vector and check each accepted result against the
  // oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      in_took  = 1'b0;
      out_took = 1'b0;
    end else begin
      in_took  = in_valid && in_ready;
      out_took = out_valid && out_ready;
      if (in_took) begin
        fresh.vec  = in_item;
        fresh.want = heading_of(in_item);
        expected_headings.push_back(fresh);
      end
      if (out_took) begin
        if (expected_headings.size() == 0) begin
          note_error($sformatf("unexpected result: heading %0d zero_vector %0b",
                               out_item.heading, out_item.zero_vector));
        end else begin
          oldest = expected_headings.pop_front();
          if (out_item.heading !== oldest.want.heading ||
              out_item.zero_vector !== oldest.want.zero_vector)
            note_error($sformatf(
              "mismatch x=%0d z=%0d: expected heading %0d zero_vector %0b, got %0d %0b",
              oldest.vec.dir_x, oldest.vec.dir_z, oldest.want.heading,
              oldest.want.zero_vector, out_item.heading, out_item.zero_vector));
        end
      end
    end
  end

  // Input driver: advance at the falling edge. Hold valid and payload until
  // the transaction is taken, then idle for the drawn gap before the next one.
  // Burst phases draw no gap at all.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else if (!in_valid || in_took) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_vectors.size() > 0) begin
        in_item  <= pending_vectors.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 79) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: after each taken result, drop ready for a drawn stall.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 79) == 0) take_burst = !take_burst;
        take_wait = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (take_wait > 0) begin
        take_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int         pick;
    int         a;
    int         b;
    logic [15:0] corners [0:4];
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_item     = '0;
    out_ready   = 1'b0;
    send_wait   = 0;
    send_burst  = 1'b0;
    take_wait   = 0;
    take_burst  = 1'b0;
    error_count = 0;
    cycle_count = 0;
    corners     = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

    // Directed: zero vector, the four axes, full-scale components, the
    // diagonals, and vectors just either side of the 0/360 and 180 seams
    queue_vector(0, 0);
    queue_vector(1, 0);
    queue_vector(0, 1);
    queue_vector(-1, 0);
    queue_vector(0, -1);
    queue_vector(32767, 0);
    queue_vector(-32768, 0);
    queue_vector(0, 32767);
    queue_vector(0, -32768);
    queue_vector(32767, 32767);
    queue_vector(-32768, -32768);
    queue_vector(-32768, 32767);
    queue_vector(32767, -32768);
    queue_vector(1, 1);
    queue_vector(-1, 1);
    queue_vector(-1, -1);
    queue_vector(1, -1);
    queue_vector(32767, -1);
    queue_vector(32767, 1);
    queue_vector(-32768, 1);
    queue_vector(-32768, -1);
    queue_vector(-1, 32767);
    queue_vector(1, -32768);
    queue_vector(0, 0);

    // Random: half full-range components, the other half small vectors, axis and
    // near-axis vectors, diagonals and corner values
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 9);
      a    = int'($urandom_range(0, 65535)) - 32768;
      b    = int'($urandom_range(0, 8)) - 4;
      case (pick)
        0, 1, 2, 3, 4: queue_vector(int'(16'($urandom)), int'(16'($urandom)));
        5: queue_vector(b, int'($urandom_range(0, 8)) - 4);
        6: begin
          if ($urandom_range(0, 1)) queue_vector(a, 0);
          else queue_vector(0, a);
        end
        7: begin
          if ($urandom_range(0, 1)) queue_vector(a, b);
          else queue_vector(b, a);
        end
        8: queue_vector($urandom_range(0, 1) ? a : -a, $urandom_range(0, 1) ? a : -a);
        default: queue_vector($signed(corners[$urandom_range(0, 4)]),
                              $signed(corners[$urandom_range(0, 4)]));
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every vector offered and taken, every heading returned, then
    // leave room for any stray result to show up
    while (pending_vectors.size() != 0 || in_valid) @(posedge clk);
    while (expected_headings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vhd_pkg.sv
rtl/core/vector_heading_degrees.sv
test/vector_heading_degrees_test.sv
